/* hw/rtl/match_timer_with_prescaler_assert.svh */
// Assertion macros shared by the timer RTL.
`ifndef MATCH_TIMER_WITH_PRESCALER_ASSERT_SVH
`define MATCH_TIMER_WITH_PRESCALER_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define MTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MTP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/mtp_pkg.sv */
// Shared types and register map constants of the match timer.
package mtp_pkg;

	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [7:0] OFS_MATCH   = 8'h24;
	localparam logic [7:0] OFS_COUNT   = 8'h28;
	localparam logic [7:0] OFS_ENABLE  = 8'h2c;
	localparam logic [7:0] OFS_CLEAR   = 8'h30;
	localparam logic [7:0] OFS_DIVIDER = 8'h34;
	localparam logic [7:0] OFS_STATUS  = 8'h88;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              match_pulse;
	} mtp_result_t;

endpackage

/* hw/rtl/mtp_core.sv */
// Timer registers, prescaler and counter; one item updated per accepted cycle.
`include "match_timer_with_prescaler_assert.svh"

module mtp_core #(
	parameter int unsigned COUNTER_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          kind,
	input  logic [7:0]          offset,
	input  logic [31:0]         write_data,
	output mtp_pkg::mtp_result_t result
);
	import mtp_pkg::*;

	logic [COUNTER_BITS-1:0] count_q, count_d;
	logic [COUNTER_BITS-1:0] match_q, match_d;
	logic                    run_q, run_d;
	logic                    com_q, com_d;
	logic [1:0]              div_q, div_d;
	logic [1:0]              presc_q, presc_d;
	logic [COUNTER_BITS-1:0] count_inc;
	logic                    hit;

	assign count_inc = count_q + COUNTER_BITS'(1);

	always_comb begin
		count_d            = count_q;
		match_d            = match_q;
		run_d              = run_q;
		com_d              = com_q;
		div_d              = div_q;
		presc_d            = presc_q;
		hit                = 1'b0;
		result.read_data   = '0;
		result.match_pulse = 1'b0;
		case (kind)
			KIND_READ: begin
				case (offset)
					OFS_MATCH:   result.read_data = DATA_W'(match_q);
					OFS_COUNT:   result.read_data = DATA_W'(count_q);
					OFS_ENABLE,
					OFS_STATUS:  result.read_data = DATA_W'({com_q, run_q});
					OFS_DIVIDER: result.read_data = DATA_W'(div_q);
					default:     result.read_data = '0;
				endcase
			end
			KIND_WRITE: begin
				case (offset)
					OFS_MATCH: match_d = write_data[COUNTER_BITS-1:0];
					OFS_ENABLE: begin
						run_d = write_data[0];
						com_d = write_data[1];
					end
					OFS_CLEAR: begin
						count_d = '0;
						presc_d = '0;
					end
					OFS_DIVIDER: div_d = write_data[1:0];
					default: ;
				endcase
			end
			KIND_TICK: begin
				if (run_q) begin
					// a lowered divider never strands the prescaler
					if (presc_q >= div_q) begin
						presc_d = '0;
						hit     = (count_inc == match_q);
						count_d = (hit && com_q) ? '0 : count_inc;
					end else begin
						presc_d = presc_q + 2'd1;
					end
				end
				result.match_pulse = hit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			match_q <= '0;
			run_q   <= 1'b0;
			com_q   <= 1'b0;
			div_q   <= '0;
			presc_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
			match_q <= match_d;
			run_q   <= run_d;
			com_q   <= com_d;
			div_q   <= div_d;
			presc_q <= presc_d;
		end
	end

	`MTP_ASSERT(a_clear_zeroes, accept && kind == KIND_WRITE && offset == OFS_CLEAR |=> count_q == '0 && presc_q == '0, "clear write left count running")
	`MTP_ASSERT(a_stopped_holds, accept && kind == KIND_TICK && !run_q |=> $stable(count_q) && $stable(presc_q), "stopped timer moved")
	`MTP_ASSERT(a_match_clears, accept && result.match_pulse && com_q |=> count_q == '0, "clear-on-match did not zero count")

endmodule

/* hw/rtl/match_timer_with_prescaler.sv */
// Top level of the match timer: input handshake, result register and skid stage.
//
// Use: each input item is a bus read, a bus write or one timer tick, given on
// kind, offset and write_data with in_valid; it is taken on a rising edge with
// in_valid high and in_stall low. Every item yields exactly one result item
// (read_data, match_pulse) on the output channel, taken on an edge with
// out_valid high and out_stall low.
// An accepted item reaches out_valid in the next cycle when the output is free.
// Throughput: one item per cycle while in_stall is low; the register update and
// decode are one pass of logic from the accepted item to the result register.
// A stalled receiver fills the output register, then the one-entry skid
// stage; in_stall rises only once both hold a result, and falls as soon as
// the receiver takes one.
// Reset (arst_n low, asynchronous) zeroes count, match, enable bits, divider
// and prescaler, and drops both result entries.
`include "match_timer_with_prescaler_assert.svh"

module match_timer_with_prescaler #(
	parameter int unsigned COUNTER_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  offset,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        match_pulse
);
	import mtp_pkg::*;

	logic        accept;
	logic        out_take;
	logic        load_out;
	mtp_result_t new_res;
	mtp_result_t out_q;
	mtp_result_t skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign load_out = !out_valid_q || out_take;

	mtp_core #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind),
		.offset    (offset),
		.write_data(write_data),
		.result    (new_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= accept;
			end else begin
				out_valid_q  <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload path, no reset needed
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (accept)
					skid_q <= new_res;
			end else if (accept) begin
				out_q <= new_res;
			end
		end else if (accept) begin
			skid_q <= new_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_q.read_data;
	assign match_pulse = out_q.match_pulse;

	`MTP_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid item without output item")
	`MTP_ASSERT(a_accept_shows, accept && !out_valid_q |=> out_valid_q, "accepted item not presented")
	`MTP_ASSERT(a_drain_empties, out_take && !skid_valid_q && !accept |=> !out_valid_q, "result shown twice")

endmodule

/* bench/match_timer_with_prescaler_tb.sv */
// Self-checking testbench for the match timer: bus accesses and ticks against a timer model.
`timescale 1ns / 1ps

module match_timer_with_prescaler_tb;
	import mtp_pkg::*;

	localparam int          CNT_BITS       = 32;
	localparam logic [31:0] CNT_MASK       = 32'((64'd1 << CNT_BITS) - 64'd1);
	localparam logic [1:0]  KIND_NONE      = 2'd3;
	localparam int          CLK_PERIOD     = 8;
	localparam int          TOTAL_ITEMS    = 735;
	localparam int          HOLD_AT        = 300;
	localparam int          HOLD_CYCLES    = 48;
	localparam int          TIMEOUT_CYCLES = 200_000;
	localparam int          MAX_PRINTS     = 50;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  ofs;
		logic [31:0] data;
	} bus_item_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [1:0]  kind       = KIND_READ;
	logic [7:0]  offset     = 8'h00;
	logic [31:0] write_data = 32'd0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [31:0] read_data;
	logic        match_pulse;

	// timer model state
	logic [31:0] tmr_count, tmr_match;
	logic        tmr_run, tmr_clr_on_match;
	logic [1:0]  tmr_div, tmr_presc;

	bus_item_t   pending_items[$];
	mtp_result_t expected_results[$];
	int          mismatch_cnt = 0;

	// sender burst/gap and receiver stall pattern
	int          burst_left = 0;
	int          gap_left   = 0;
	int          taken_cnt  = 0;
	int          mode_left  = 0;
	int          stall_mode = 0;
	int          hold_left  = 0;
	logic        hold_done  = 1'b0;
	wire         hold_active = (hold_left != 0);

	match_timer_with_prescaler #(.COUNTER_BITS(CNT_BITS)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.offset     (offset),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.match_pulse(match_pulse)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void push_item(logic [1:0] k, logic [7:0] o, logic [31:0] d);
		bus_item_t it;
		it.kind = k;
		it.ofs  = o;
		it.data = d;
		pending_items.push_back(it);
	endfunction

	// Applies one item to the timer model and returns the result it causes.
	function automatic mtp_result_t timer_step(bus_item_t it);
		mtp_result_t r;
		r = '0;
		case (it.kind)
		KIND_READ: begin
			case (it.ofs)
			OFS_MATCH:              r.read_data = tmr_match & CNT_MASK;
			OFS_COUNT:              r.read_data = tmr_count & CNT_MASK;
			OFS_ENABLE, OFS_STATUS: r.read_data = {30'd0, tmr_clr_on_match, tmr_run};
			OFS_DIVIDER:            r.read_data = {30'd0, tmr_div};
			default:                r.read_data = 32'd0;
			endcase
		end
		KIND_WRITE: begin
			case (it.ofs)
			OFS_MATCH: tmr_match = it.data & CNT_MASK;
			OFS_ENABLE: begin
				tmr_run          = it.data[0];
				tmr_clr_on_match = it.data[1];
			end
			OFS_CLEAR: begin
				tmr_count = 32'd0;
				tmr_presc = 2'd0;
			end
			OFS_DIVIDER: tmr_div = it.data[1:0];
			default: ;
			endcase
		end
		KIND_TICK: begin
			// a stale prescaler above a lowered divider fires at once
			if (tmr_run) begin
				if (tmr_presc >= tmr_div) begin
					tmr_presc = 2'd0;
					tmr_count = (tmr_count + 32'd1) & CNT_MASK;
					if (tmr_count == tmr_match) begin
						r.match_pulse = 1'b1;
						if (tmr_clr_on_match)
							tmr_count = 32'd0;
					end
				end else begin
					tmr_presc = tmr_presc + 2'd1;
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatch_cnt < MAX_PRINTS)
			$display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// Driver: bursts of items with random gaps; payload held while stalled.
	always @(posedge clk) begin : drive_items
		bus_item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				nxt.kind = kind;
				nxt.ofs  = offset;
				nxt.data = write_data;
				expected_results.push_back(timer_step(nxt));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0 && !hold_active) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_items.size() != 0) begin
					nxt = pending_items.pop_front();
					in_valid   <= 1'b1;
					kind       <= nxt.kind;
					offset     <= nxt.ofs;
					write_data <= nxt.data;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern in random modes, plus one long hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				taken_cnt <= taken_cnt + 1;
			if (!hold_done && taken_cnt == HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left > 1) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				if (hold_left == 1)
					hold_left <= 0;
				if (mode_left == 0) begin
					stall_mode <= $urandom_range(0, 2);
					mode_left  <= $urandom_range(8, 64);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Monitor: each taken result against the oldest expectation.
	always @(posedge clk) begin : check_results
		mtp_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", read_data, 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (read_data !== want.read_data)
					report_mismatch("read_data", read_data, want.read_data);
				if (match_pulse !== want.match_pulse)
					report_mismatch("match_pulse", {31'd0, match_pulse},
						{31'd0, want.match_pulse});
			end
		end
	end

	initial begin
		logic [7:0] reg_ofs[6];
		int         n;

		reg_ofs = '{OFS_MATCH, OFS_COUNT, OFS_ENABLE, OFS_CLEAR, OFS_DIVIDER, OFS_STATUS};
		tmr_count        = 32'd0;
		tmr_match        = 32'd0;
		tmr_run          = 1'b0;
		tmr_clr_on_match = 1'b0;
		tmr_div          = 2'd0;
		tmr_presc        = 2'd0;

		// reset values, wide writes, ignored writes, unknown offset and kind
		push_item(KIND_READ,  OFS_MATCH,   32'd0);
		push_item(KIND_READ,  OFS_COUNT,   32'd0);
		push_item(KIND_READ,  OFS_ENABLE,  32'd0);
		push_item(KIND_READ,  OFS_CLEAR,   32'd0);
		push_item(KIND_READ,  OFS_STATUS,  32'd0);
		push_item(KIND_WRITE, OFS_MATCH,   32'hffff_ffff);
		push_item(KIND_READ,  OFS_MATCH,   32'd0);
		push_item(KIND_WRITE, OFS_DIVIDER, 32'hffff_ffff);
		push_item(KIND_READ,  OFS_DIVIDER, 32'd0);
		push_item(KIND_WRITE, OFS_COUNT,   32'hdead_beef);
		push_item(KIND_WRITE, OFS_STATUS,  32'hffff_ffff);
		push_item(KIND_WRITE, 8'hff,       32'hffff_ffff);
		push_item(KIND_READ,  8'hff,       32'd0);
		push_item(KIND_NONE,  OFS_MATCH,   32'hffff_ffff);
		push_item(KIND_TICK,  OFS_COUNT,   32'd0);
		// run with clear-on-match, divide by four, then lower the divider mid-count
		push_item(KIND_WRITE, OFS_MATCH,   32'd2);
		push_item(KIND_WRITE, OFS_ENABLE,  32'hffff_ffff);
		push_item(KIND_READ,  OFS_STATUS,  32'd0);
		repeat (3) push_item(KIND_TICK, 8'h00, 32'd0);
		push_item(KIND_WRITE, OFS_DIVIDER, 32'd0);
		repeat (3) push_item(KIND_TICK, 8'h00, 32'd0);
		push_item(KIND_WRITE, OFS_CLEAR,   32'd0);
		push_item(KIND_READ,  OFS_COUNT,   32'd0);

		while (pending_items.size() < TOTAL_ITEMS) begin
			if ($urandom_range(0, 4) != 0) begin
				// well-formed run: divider, optional clear, mostly small match, enable, ticks, reads
				push_item(KIND_WRITE, OFS_DIVIDER,
					($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3));
				if ($urandom_range(0, 3) != 0)
					push_item(KIND_WRITE, OFS_CLEAR, $urandom);
				push_item(KIND_WRITE, OFS_MATCH,
					($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 12));
				push_item(KIND_WRITE, OFS_ENABLE,
					(($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 3)) | 32'd1);
				n = $urandom_range(8, 40);
				repeat (n) begin
					if ($urandom_range(0, 7) == 0)
						push_item(KIND_READ, reg_ofs[3'($urandom_range(0, 5))], $urandom);
					else
						push_item(KIND_TICK, 8'($urandom_range(0, 255)), $urandom);
				end
				if ($urandom_range(0, 3) == 0) begin
					// stopped timer keeps its prescaler
					push_item(KIND_WRITE, OFS_ENABLE, $urandom & 32'hffff_fffe);
					repeat (3) push_item(KIND_TICK, 8'($urandom_range(0, 255)), $urandom);
					push_item(KIND_READ, OFS_COUNT, $urandom);
				end
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					push_item(2'($urandom_range(0, 3)),
						($urandom_range(0, 1) != 0) ? reg_ofs[3'($urandom_range(0, 5))]
							: 8'($urandom_range(0, 255)),
						$urandom);
				end
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("timeout after %0d cycles, %0d results outstanding",
			TIMEOUT_CYCLES, expected_results.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
